@@ sv/utc_to_local_date_time_assert.svh @@
// Assertion macros shared by the checker of the UTC to local date and time block.
// Needs nothing else; include by bare file name.
`ifndef UTC_TO_LOCAL_DATE_TIME_ASSERT_SVH
`define UTC_TO_LOCAL_DATE_TIME_ASSERT_SVH

// same-cycle implication
`define ULDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ULDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/uldt_pkg.sv @@
// Package for the UTC to local date and time block: field widths, calendar
// constants, reciprocal multipliers, pipeline control types. No dependencies.
package uldt_pkg;

	localparam int unsigned WdW   = 3;
	localparam int unsigned DayW  = 5;
	localparam int unsigned MonW  = 4;
	localparam int unsigned YearW = 14;
	localparam int unsigned HourW = 5;
	localparam int unsigned MinW  = 6;
	localparam int unsigned SecW  = 6;
	localparam int unsigned TzW   = 11;

	// minutes of day, signed, before wrap (-1024 .. 2947)
	localparam int unsigned MdayW = 13;
	// wrapped minutes of day (0 .. 1439)
	localparam int unsigned MadjW = 11;

	localparam int unsigned SecPerMin  = 60;
	localparam int unsigned MinPerHour = 60;
	localparam int unsigned MinPerDay  = 24 * 60;

	localparam logic [MonW-1:0]  MonJan = 4'd1;
	localparam logic [MonW-1:0]  MonFeb = 4'd2;
	localparam logic [MonW-1:0]  MonApr = 4'd4;
	localparam logic [MonW-1:0]  MonJun = 4'd6;
	localparam logic [MonW-1:0]  MonSep = 4'd9;
	localparam logic [MonW-1:0]  MonNov = 4'd11;
	localparam logic [MonW-1:0]  MonDec = 4'd12;

	localparam logic [WdW-1:0]   WdMon = 3'd1;
	localparam logic [WdW-1:0]   WdSun = 3'd7;

	localparam logic [YearW-1:0] YearMax = 14'd16383;

	// floor(y / 25) = (y * 5243) >> 17 for y < 2^14
	localparam int unsigned Div25Mul   = 5243;
	localparam int unsigned Div25Shift = 17;
	localparam int unsigned Div25ProdW = 27;
	localparam int unsigned Div25QW    = 10;

	// floor(m / 60) = (m * 1093) >> 16 for m < 1440
	localparam int unsigned Div60Mul   = 1093;
	localparam int unsigned Div60Shift = 16;
	localparam int unsigned Div60ProdW = 21;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} adv_t;

	typedef struct packed {
		logic back;
		logic fwd;
	} step_t;

	function automatic logic [DayW-1:0] days_in(input logic [MonW-1:0] month,
			input logic leap);
		logic [DayW-1:0] len;
		unique case (month)
			MonFeb: len = leap ? 5'd29 : 5'd28;
			MonApr, MonJun, MonSep, MonNov: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ sv/uldt_if.sv @@
// Word channels of the UTC to local date and time block: UTC input and local output.
// Depends on uldt_pkg for field widths.
interface uldt_in_if;
	logic                        valid;
	logic                        ready;
	logic [uldt_pkg::WdW-1:0]    in_weekday;
	logic [uldt_pkg::DayW-1:0]   in_day;
	logic [uldt_pkg::MonW-1:0]   in_month;
	logic [uldt_pkg::YearW-1:0]  in_year;
	logic [uldt_pkg::HourW-1:0]  in_hour;
	logic [uldt_pkg::MinW-1:0]   in_minute;
	logic [uldt_pkg::SecW-1:0]   in_second;

	modport source (output valid, in_weekday, in_day, in_month, in_year, in_hour,
		in_minute, in_second, input ready);
	modport sink (input valid, in_weekday, in_day, in_month, in_year, in_hour,
		in_minute, in_second, output ready);
endinterface

interface uldt_out_if;
	logic                        valid;
	logic                        ready;
	logic [uldt_pkg::WdW-1:0]    out_weekday;
	logic [uldt_pkg::DayW-1:0]   out_day;
	logic [uldt_pkg::MonW-1:0]   out_month;
	logic [uldt_pkg::YearW-1:0]  out_year;
	logic [uldt_pkg::HourW-1:0]  out_hour;
	logic [uldt_pkg::MinW-1:0]   out_minute;
	logic [uldt_pkg::SecW-1:0]   out_second;

	modport source (output valid, out_weekday, out_day, out_month, out_year, out_hour,
		out_minute, out_second, input ready);
	modport sink (input valid, out_weekday, out_day, out_month, out_year, out_hour,
		out_minute, out_second, output ready);
endinterface

@@ sv/uldt_tod.sv @@
// Time-of-day datapath: offset add, day wrap, hour/minute split over four stages.
// Depends on uldt_pkg.
module uldt_tod (
	input  logic                          clk,
	input  uldt_pkg::adv_t                adv,
	input  logic [uldt_pkg::HourW-1:0]    hour,
	input  logic [uldt_pkg::MinW-1:0]     minute,
	input  logic [uldt_pkg::SecW-1:0]     second,
	input  logic [uldt_pkg::TzW-1:0]      tz,
	output uldt_pkg::step_t               step_s2,
	output logic [uldt_pkg::HourW-1:0]    hour_s4,
	output logic [uldt_pkg::MinW-1:0]     minute_s4,
	output logic [uldt_pkg::SecW-1:0]     second_s4
);

	// stage 1: seconds carry and signed minutes of day
	logic                            sec_wrap;
	logic [uldt_pkg::SecW-1:0]       sec_n;
	logic [uldt_pkg::MadjW-1:0]      hour_min;
	logic [uldt_pkg::MdayW-1:0]      mday_n;
	logic [uldt_pkg::MdayW-1:0]      mday_s1;
	logic [uldt_pkg::SecW-1:0]       sec_s1;

	always_comb begin
		sec_wrap = second >= uldt_pkg::SecW'(uldt_pkg::SecPerMin);
		sec_n    = sec_wrap ? second - uldt_pkg::SecW'(uldt_pkg::SecPerMin) : second;
		hour_min = uldt_pkg::MadjW'(hour) * uldt_pkg::MadjW'(uldt_pkg::MinPerHour);
		mday_n   = uldt_pkg::MdayW'(hour_min) + uldt_pkg::MdayW'(minute)
			+ uldt_pkg::MdayW'(sec_wrap)
			+ {{(uldt_pkg::MdayW - uldt_pkg::TzW){tz[uldt_pkg::TzW-1]}}, tz};
	end

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			mday_s1 <= mday_n;
			sec_s1  <= sec_n;
		end
	end

	// stage 2: wrap into one day, note the day step, saturate a second overflow
	logic                            neg;
	logic                            over;
	logic                            over2;
	logic [uldt_pkg::MadjW-1:0]      madj_n;
	logic [uldt_pkg::MadjW-1:0]      madj_s2;
	logic [uldt_pkg::SecW-1:0]       sec_s2;

	always_comb begin
		neg   = mday_s1[uldt_pkg::MdayW-1];
		over  = !neg && (mday_s1[uldt_pkg::MdayW-2:0]
			>= (uldt_pkg::MdayW-1)'(uldt_pkg::MinPerDay));
		over2 = !neg && (mday_s1[uldt_pkg::MdayW-2:0]
			>= (uldt_pkg::MdayW-1)'(2 * uldt_pkg::MinPerDay));
		priority if (neg) begin
			madj_n = uldt_pkg::MadjW'(mday_s1 + uldt_pkg::MdayW'(uldt_pkg::MinPerDay));
		end else if (over2) begin
			madj_n = uldt_pkg::MadjW'(uldt_pkg::MinPerDay - 1);
		end else if (over) begin
			madj_n = uldt_pkg::MadjW'(mday_s1 - uldt_pkg::MdayW'(uldt_pkg::MinPerDay));
		end else begin
			madj_n = uldt_pkg::MadjW'(mday_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			madj_s2      <= madj_n;
			sec_s2       <= over2 ? uldt_pkg::SecW'(uldt_pkg::SecPerMin - 1) : sec_s1;
			step_s2.back <= neg;
			step_s2.fwd  <= over;
		end
	end

	// stage 3: reciprocal product for the hour
	logic [uldt_pkg::Div60ProdW-1:0] prod_s3;
	logic [uldt_pkg::MadjW-1:0]      madj_s3;
	logic [uldt_pkg::SecW-1:0]       sec_s3;

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			prod_s3 <= uldt_pkg::Div60ProdW'(madj_s2)
				* uldt_pkg::Div60ProdW'(uldt_pkg::Div60Mul);
			madj_s3 <= madj_s2;
			sec_s3  <= sec_s2;
		end
	end

	// stage 4: hour and minute remainder
	logic [uldt_pkg::HourW-1:0]      hour_n;
	logic [uldt_pkg::MadjW-1:0]      min_rem;

	always_comb begin
		hour_n  = prod_s3[uldt_pkg::Div60Shift +: uldt_pkg::HourW];
		min_rem = madj_s3 - uldt_pkg::MadjW'(hour_n)
			* uldt_pkg::MadjW'(uldt_pkg::MinPerHour);
	end

	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			hour_s4   <= hour_n;
			minute_s4 <= uldt_pkg::MinW'(min_rem);
			second_s4 <= sec_s3;
		end
	end

endmodule

@@ sv/uldt_date.sv @@
// Date datapath: input clamping, Gregorian leap test, one-day step with rollover.
// Depends on uldt_pkg; takes the day step from uldt_tod at stage 2.
module uldt_date (
	input  logic                          clk,
	input  uldt_pkg::adv_t                adv,
	input  logic [uldt_pkg::WdW-1:0]      weekday,
	input  logic [uldt_pkg::DayW-1:0]     day,
	input  logic [uldt_pkg::MonW-1:0]     month,
	input  logic [uldt_pkg::YearW-1:0]    year,
	input  uldt_pkg::step_t               step_s2,
	output logic [uldt_pkg::WdW-1:0]      weekday_s4,
	output logic [uldt_pkg::DayW-1:0]     day_s4,
	output logic [uldt_pkg::MonW-1:0]     month_s4,
	output logic [uldt_pkg::YearW-1:0]    year_s4
);

	// stage 1: clamp fields, quotient of year by 25
	logic [uldt_pkg::Div25ProdW-1:0] yprod;
	logic [uldt_pkg::WdW-1:0]        wd_s1;
	logic [uldt_pkg::DayW-1:0]       d_s1;
	logic [uldt_pkg::MonW-1:0]       m_s1;
	logic [uldt_pkg::YearW-1:0]      y_s1;
	logic [uldt_pkg::Div25QW-1:0]    q25_s1;

	assign yprod = uldt_pkg::Div25ProdW'(year) * uldt_pkg::Div25ProdW'(uldt_pkg::Div25Mul);

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			wd_s1  <= (weekday == '0) ? uldt_pkg::WdSun : weekday;
			d_s1   <= (day == '0) ? uldt_pkg::DayW'(1) : day;
			if (month == '0) begin
				m_s1 <= uldt_pkg::MonJan;
			end else if (month > uldt_pkg::MonDec) begin
				m_s1 <= uldt_pkg::MonDec;
			end else begin
				m_s1 <= month;
			end
			y_s1   <= year;
			q25_s1 <= yprod[uldt_pkg::Div25Shift +: uldt_pkg::Div25QW];
		end
	end

	// stage 2: leap year, month length, day clamp
	logic                            div25;
	logic                            leap;
	logic [uldt_pkg::DayW-1:0]       len;
	logic [uldt_pkg::WdW-1:0]        wd_s2;
	logic [uldt_pkg::DayW-1:0]       d_s2;
	logic [uldt_pkg::MonW-1:0]       m_s2;
	logic [uldt_pkg::YearW-1:0]      y_s2;
	logic [uldt_pkg::DayW-1:0]       len_s2;
	logic                            leap_s2;

	always_comb begin
		div25 = (uldt_pkg::YearW'(q25_s1) * uldt_pkg::YearW'(25)) == y_s1;
		// divisible by 400 is divisible by 16 and by 25
		leap  = ((y_s1[1:0] == 2'b00) && !div25) || ((y_s1[3:0] == 4'b0000) && div25);
		len   = uldt_pkg::days_in(m_s1, leap);
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			wd_s2   <= wd_s1;
			d_s2    <= (d_s1 > len) ? len : d_s1;
			m_s2    <= m_s1;
			y_s2    <= y_s1;
			len_s2  <= len;
			leap_s2 <= leap;
		end
	end

	// stage 3: day step back or forward
	logic [uldt_pkg::WdW-1:0]        wd_n;
	logic [uldt_pkg::DayW-1:0]       d_n;
	logic [uldt_pkg::MonW-1:0]       m_n;
	logic [uldt_pkg::YearW-1:0]      y_n;
	logic [uldt_pkg::WdW-1:0]        wd_s3;
	logic [uldt_pkg::DayW-1:0]       d_s3;
	logic [uldt_pkg::MonW-1:0]       m_s3;
	logic [uldt_pkg::YearW-1:0]      y_s3;

	always_comb begin
		wd_n = wd_s2;
		d_n  = d_s2;
		m_n  = m_s2;
		y_n  = y_s2;
		if (step_s2.back) begin
			if (d_s2 == uldt_pkg::DayW'(1)) begin
				if (m_s2 == uldt_pkg::MonJan) begin
					// year one stays put
					if (y_s2 > uldt_pkg::YearW'(1)) begin
						y_n = y_s2 - uldt_pkg::YearW'(1);
					end
					m_n = uldt_pkg::MonDec;
				end else begin
					m_n = m_s2 - uldt_pkg::MonW'(1);
				end
				d_n = uldt_pkg::days_in(m_n, leap_s2);
			end else begin
				d_n = d_s2 - uldt_pkg::DayW'(1);
			end
			wd_n = (wd_s2 == uldt_pkg::WdMon) ? uldt_pkg::WdSun : wd_s2 - uldt_pkg::WdW'(1);
		end else if (step_s2.fwd) begin
			if (d_s2 == len_s2) begin
				if (m_s2 == uldt_pkg::MonDec) begin
					if (y_s2 != uldt_pkg::YearMax) begin
						y_n = y_s2 + uldt_pkg::YearW'(1);
					end
					m_n = uldt_pkg::MonJan;
				end else begin
					m_n = m_s2 + uldt_pkg::MonW'(1);
				end
				d_n = uldt_pkg::DayW'(1);
			end else begin
				d_n = d_s2 + uldt_pkg::DayW'(1);
			end
			wd_n = (wd_s2 == uldt_pkg::WdSun) ? uldt_pkg::WdMon : wd_s2 + uldt_pkg::WdW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			wd_s3 <= wd_n;
			d_s3  <= d_n;
			m_s3  <= m_n;
			y_s3  <= y_n;
		end
	end

	// stage 4: aligned with the time-of-day split
	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			weekday_s4 <= wd_s3;
			day_s4     <= d_s3;
			month_s4   <= m_s3;
			year_s4    <= y_s3;
		end
	end

endmodule

@@ sv/utc_to_local_date_time.sv @@
// UTC to local date and time: four register stages, one word per cycle sustained
// while the output side is ready. A word accepted into stage 1 moves through stages
// 2 and 3 into stage 4, which drives the output. Ready is taken back through the
// stage valid bits, so empty stages absorb a stall.
// Reset clears the stage valid bits and sets the offset register to zero.
// Depends on uldt_pkg, uldt_if, uldt_tod, uldt_date.
module utc_to_local_date_time (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [uldt_pkg::TzW-1:0]     tz_offset_minutes,
	uldt_in_if.sink                      in_ch,
	uldt_out_if.source                   out_ch
);

	logic [uldt_pkg::TzW-1:0] tz_q;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic                     v_s4;
	uldt_pkg::adv_t           adv;
	uldt_pkg::step_t          step_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= '0;
		end else if (cfg_we) begin
			tz_q <= tz_offset_minutes;
		end
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv.en_s4 = !v_s4 || out_ch.ready;
		adv.en_s3 = !v_s3 || adv.en_s4;
		adv.en_s2 = !v_s2 || adv.en_s3;
		adv.en_s1 = !v_s1 || adv.en_s2;
	end

	assign in_ch.ready  = adv.en_s1;
	assign out_ch.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.en_s1) begin
				v_s1 <= in_ch.valid;
			end
			if (adv.en_s2) begin
				v_s2 <= v_s1;
			end
			if (adv.en_s3) begin
				v_s3 <= v_s2;
			end
			if (adv.en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	uldt_tod u_tod (
		.clk       (clk),
		.adv       (adv),
		.hour      (in_ch.in_hour),
		.minute    (in_ch.in_minute),
		.second    (in_ch.in_second),
		.tz        (tz_q),
		.step_s2   (step_s2),
		.hour_s4   (out_ch.out_hour),
		.minute_s4 (out_ch.out_minute),
		.second_s4 (out_ch.out_second)
	);

	uldt_date u_date (
		.clk        (clk),
		.adv        (adv),
		.weekday    (in_ch.in_weekday),
		.day        (in_ch.in_day),
		.month      (in_ch.in_month),
		.year       (in_ch.in_year),
		.step_s2    (step_s2),
		.weekday_s4 (out_ch.out_weekday),
		.day_s4     (out_ch.out_day),
		.month_s4   (out_ch.out_month),
		.year_s4    (out_ch.out_year)
	);

endmodule

@@ sv/uldt_check.sv @@
// Port-level checker for utc_to_local_date_time, bound to the top level.
// Depends on uldt_pkg and utc_to_local_date_time_assert.svh.
`include "utc_to_local_date_time_assert.svh"

module uldt_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [uldt_pkg::WdW-1:0]     out_weekday,
	input logic [uldt_pkg::DayW-1:0]    out_day,
	input logic [uldt_pkg::MonW-1:0]    out_month,
	input logic [uldt_pkg::HourW-1:0]   out_hour,
	input logic [uldt_pkg::MinW-1:0]    out_minute,
	input logic [uldt_pkg::SecW-1:0]    out_second
);

	logic [uldt_pkg::WdW + uldt_pkg::DayW + uldt_pkg::MonW + uldt_pkg::HourW
		+ uldt_pkg::MinW + uldt_pkg::SecW:0] out_word;
	logic                                    out_stall;
	logic                                    tod_ok;
	logic                                    date_ok;

	assign out_word  = {out_valid, out_weekday, out_day, out_month, out_hour, out_minute,
		out_second};
	assign out_stall = out_valid && !out_ready;
	assign tod_ok    = (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59);
	assign date_ok   = (out_weekday != '0) && (out_day != '0)
		&& (out_month >= uldt_pkg::MonJan) && (out_month <= uldt_pkg::MonDec);

	// a stalled output word holds, valid included
	`ULDT_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, $stable(out_word), "unheld word")

	// a free output side frees the whole pipeline
	`ULDT_ASSERT_IMP(a_ready_path, clk, arst_n, out_ready, in_ready, "input stalled")

	`ULDT_ASSERT_IMP(a_tod_range, clk, arst_n, out_valid, tod_ok, "time of day out of range")

	`ULDT_ASSERT_IMP(a_date_range, clk, arst_n, out_valid, date_ok, "date field out of range")

endmodule

bind utc_to_local_date_time uldt_check u_uldt_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_weekday (out_ch.out_weekday),
	.out_day     (out_ch.out_day),
	.out_month   (out_ch.out_month),
	.out_hour    (out_ch.out_hour),
	.out_minute  (out_ch.out_minute),
	.out_second  (out_ch.out_second)
);
